@@ sv/lcgurip_pkg.sv @@
// Shared types and constants for the LCG unique random index picker.
package lcgurip_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned MOD_STEPS = DATA_W;
  localparam int unsigned STEP_W  = $clog2(MOD_STEPS);
  // Index field reaches 255, so no table deeper than 256 entries is ever read
  localparam int unsigned IDX_SPAN = 1 << IDX_W;
  localparam int unsigned CMP_W   = 13;

  localparam logic [DATA_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [DATA_W-1:0] LCG_INC = 32'd1013904223;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MSTART,
    ST_MWAIT,
    ST_RD,
    ST_CMP,
    ST_APPEND,
    ST_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic mod_start;
    logic scan_clr;
    logic scan_inc;
    logic rd;
    logic wr;
    logic cnt_inc;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_bad;
    logic mod_done;
    logic cnt_zero;
    logic match;
    logic scan_last;
    logic cnt_at_idx;
    logic out_free;
  } sts_t;

endpackage

@@ sv/lcg_unique_random_index_picker.sv @@
// Picks the value at a given position of a no-repeat LCG sequence, one item at a time.
// An invalid request skips the generator and goes straight to the done state, where
// its result word is loaded into the output register once that register is free.
// A valid request steps the generator, runs the 32-step bit-serial remainder and scans
// the single-port table for each candidate until the value at its index is appended.
// Throughput: one item in flight; reset clears control state only, the table is not cleared.
module lcg_unique_random_index_picker
  import lcgurip_pkg::*;
#(
  parameter int unsigned SEQ_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DATA_W-1:0] in_seed_value,
  input  logic [DATA_W-1:0] in_range_size,
  input  logic [IDX_W-1:0]  in_element_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_picked_value,
  output logic              out_invalid
);

  cmd_t cmd;
  sts_t sts;

  lcgurip_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  lcgurip_dp #(
    .SEQ_DEPTH(SEQ_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_seed_value   (in_seed_value),
    .in_range_size   (in_range_size),
    .in_element_index(in_element_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_picked_value(out_picked_value),
    .out_invalid     (out_invalid)
  );

  // An invalid result word always carries a zero value
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invalid |-> out_picked_value == '0)
    else $error("invalid result word with nonzero value");

  // Only one item is worked on at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // Table port never reads and writes in one cycle
  a_tbl_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd && cmd.wr))
    else $error("table read and write collide");

  // A result word is loaded only when the output register is free
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result word overwritten before taken");

endmodule

@@ sv/lcgurip_ram.sv @@
// Generic single-port RAM with registered read.
module lcgurip_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/lcgurip_mod.sv @@
// Bit-serial remainder unit: one restoring step per cycle.
module lcgurip_mod
  import lcgurip_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] remainder
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DATA_W-1:0] dvd_r, dvd_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W:0]   trial;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial    = {rem_r, dvd_r[DATA_W-1]};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DATA_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DATA_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[DATA_W-1:0];
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

@@ sv/lcgurip_dp.sv @@
// Datapath: generator, remainder unit, picked table and result register.
module lcgurip_dp
  import lcgurip_pkg::*;
#(
  parameter int unsigned SEQ_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [DATA_W-1:0] in_seed_value,
  input  logic [DATA_W-1:0] in_range_size,
  input  logic [IDX_W-1:0]  in_element_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_picked_value,
  output logic              out_invalid
);

  localparam int unsigned TBL_DEPTH = (SEQ_DEPTH < IDX_SPAN) ? SEQ_DEPTH : IDX_SPAN;
  localparam int unsigned AW        = $clog2(TBL_DEPTH);

  logic [DATA_W-1:0] gen_r, gen_nxt;
  logic [DATA_W-1:0] range_r;
  logic [AW-1:0]     index_r;
  logic              inv_r;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     scan_r, scan_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_picked_r;
  logic              out_invalid_r;
  logic [DATA_W-1:0] prod;
  logic [DATA_W-1:0] cand;
  logic              mod_done;
  logic [DATA_W-1:0] ram_rdata;
  logic [AW-1:0]     ram_addr;
  logic              bad_range, bad_depth;

  // Check the request against range and table depth
  assign bad_range = DATA_W'(in_element_index) >= in_range_size;
  assign bad_depth = CMP_W'(in_element_index) >= CMP_W'(SEQ_DEPTH);

  // Advance the generator
  assign prod    = gen_r * LCG_MUL;
  assign gen_nxt = cmd.load ? in_seed_value : (cmd.step ? prod + LCG_INC : gen_r);

  always_ff @(posedge clk) begin
    gen_r <= gen_nxt;
    if (cmd.load) begin
      range_r <= in_range_size;
      index_r <= AW'(in_element_index);
      inv_r   <= bad_range | bad_depth;
    end
  end

  lcgurip_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mod_start),
    .dividend (gen_r),
    .divisor  (range_r),
    .done     (mod_done),
    .remainder(cand)
  );

  // Count accepted values and walk the table
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + AW'(1);
    end
    scan_nxt = scan_r;
    if (cmd.scan_clr) begin
      scan_nxt = '0;
    end else if (cmd.scan_inc) begin
      scan_nxt = scan_r + AW'(1);
    end
  end

  assign ram_addr = cmd.wr ? cnt_r : scan_r;

  lcgurip_ram #(
    .WIDTH(DATA_W),
    .DEPTH(TBL_DEPTH)
  ) u_tbl (
    .clk  (clk),
    .en   (cmd.rd | cmd.wr),
    .we   (cmd.wr),
    .addr (ram_addr),
    .wdata(cand),
    .rdata(ram_rdata)
  );

  // Hold the result word until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_picked_r  <= inv_r ? '0 : cand;
      out_invalid_r <= inv_r;
    end
  end

  assign sts.in_bad     = bad_range | bad_depth;
  assign sts.mod_done   = mod_done;
  assign sts.cnt_zero   = cnt_r == '0;
  assign sts.match      = ram_rdata == cand;
  assign sts.scan_last  = scan_r == (cnt_r - AW'(1));
  assign sts.cnt_at_idx = cnt_r == index_r;
  assign sts.out_free   = ~out_valid_r | out_ready;

  assign out_valid        = out_valid_r;
  assign out_picked_value = out_picked_r;
  assign out_invalid      = out_invalid_r;

endmodule

@@ sv/lcgurip_ctrl.sv @@
// Controller state machine: sequences generator steps, table scans and appends.
module lcgurip_ctrl
  import lcgurip_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_bad ? ST_DONE : ST_STEP;
        end
      end
      ST_STEP:   state_nxt = ST_MSTART;
      ST_MSTART: state_nxt = ST_MWAIT;
      ST_MWAIT: begin
        if (sts.mod_done) begin
          state_nxt = sts.cnt_zero ? ST_APPEND : ST_RD;
        end
      end
      ST_RD: state_nxt = ST_CMP;
      ST_CMP: begin
        if (sts.match) begin
          state_nxt = ST_STEP;
        end else if (sts.scan_last) begin
          state_nxt = ST_APPEND;
        end else begin
          state_nxt = ST_RD;
        end
      end
      ST_APPEND: state_nxt = sts.cnt_at_idx ? ST_DONE : ST_STEP;
      ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_STEP:   cmd.step = 1'b1;
      ST_MSTART: cmd.mod_start = 1'b1;
      ST_MWAIT:  cmd.scan_clr = sts.mod_done;
      ST_RD:     cmd.rd = 1'b1;
      ST_CMP:    cmd.scan_inc = ~sts.match & ~sts.scan_last;
      ST_APPEND: begin
        cmd.wr      = 1'b1;
        cmd.cnt_inc = ~sts.cnt_at_idx;
      end
      ST_DONE:   cmd.out_load = sts.out_free;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
